// File: rtl/uer_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uer_pkg: shared types and constants of the ultrasonic echo ranger
// Payload structs, register map, opcodes and timing constants used by the
// ranger's modules.
// ----------------------------------------------------------------------------
package uer_pkg;

  // Configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_PERIOD = 2'd1;
  localparam logic [1:0] REG_TPU    = 2'd2;

  localparam logic       MODE_RST   = 1'b0;
  localparam logic [9:0] PERIOD_RST = 10'd60;
  localparam logic [9:0] TPU_RST    = 10'd400;

  // Opcodes of an input item; the unused code behaves as a plain tick.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  localparam logic       MODE_ONESHOT = 1'b0;

  // Timing constants
  localparam logic [3:0]  TRIG_US   = 4'd10;
  localparam logic [10:0] US_PER_MS = 11'd1000;
  localparam logic [15:0] ECHO_MAX  = 16'hFFFF;
  // Distance scale: cm = us * CM_NUM / CM_DEN
  localparam logic [10:0] CM_NUM    = 11'd17;
  localparam logic [10:0] CM_DEN    = 11'd1000;

  localparam int RING_DEPTH_DEF = 5;
  localparam int DIST_W         = 11;

  typedef struct packed {
    logic [1:0] opcode;
    logic       echo_level;
    logic       write_value;
  } uer_in_t;

  typedef struct packed {
    logic              trigger_out;
    logic              read_valid;
    logic [DIST_W-1:0] read_distance;
    logic              buffer_empty;
    logic              sampling_busy;
  } uer_out_t;

  // Events from the echo timer for the current tick
  typedef struct packed {
    logic              us_tick;
    logic              push;
    logic [DIST_W-1:0] push_cm;
  } uer_echo_evt_t;

  // Ring status for the current tick
  typedef struct packed {
    logic              popped;
    logic [DIST_W-1:0] pop_data;
    logic              empty;
  } uer_ring_stat_t;

  // Controller outputs for the current tick
  typedef struct packed {
    logic trigger;
    logic sampling;
    logic ring_clear;
  } uer_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/uer_echo_timer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uer_echo_timer: microsecond prescaler and echo pulse measurement
// Divides the clock into microsecond ticks and times the echo pulse. The
// distance in centimeters is kept up to date as the pulse grows, so it is
// ready when the falling edge arrives.
// ----------------------------------------------------------------------------
module uer_echo_timer (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   step,
  input  wire logic                   echo_level,
  input  wire logic [9:0]             ticks_per_us,
  output uer_pkg::uer_echo_evt_t      evt
);
  import uer_pkg::*;

  logic [9:0]        presc_r, presc_nxt;
  logic [15:0]       us_r, us_nxt;
  logic [DIST_W-1:0] cm_r, cm_nxt;
  logic [9:0]        rem_r, rem_nxt;
  logic              prev_r;

  logic [9:0]  tpu_eff;
  logic        us_tick;
  logic        rise;
  logic        fall;
  logic [10:0] rem_sum;

  always_comb begin
    tpu_eff = (ticks_per_us == 10'd0) ? 10'd1 : ticks_per_us;
    us_tick = ({1'b0, presc_r} + 11'd1) >= {1'b0, tpu_eff};
    presc_nxt = us_tick ? 10'd0 : presc_r + 10'd1;

    rise = echo_level && !prev_r;
    fall = !echo_level && prev_r;

    us_nxt  = rise ? 16'd0 : us_r;
    cm_nxt  = rise ? '0 : cm_r;
    rem_nxt = rise ? 10'd0 : rem_r;
    rem_sum = {1'b0, rem_nxt} + CM_NUM;

    // Each counted microsecond adds 17/1000 cm; carry whole centimeters out
    // of the remainder.
    if (echo_level && us_tick && (us_nxt != ECHO_MAX)) begin
      us_nxt = us_nxt + 16'd1;
      if (rem_sum >= CM_DEN) begin
        rem_nxt = 10'(rem_sum - CM_DEN);
        cm_nxt  = cm_nxt + DIST_W'(1);
      end else begin
        rem_nxt = rem_sum[9:0];
      end
    end

    evt.us_tick = us_tick;
    evt.push    = fall;
    evt.push_cm = cm_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      presc_r <= 10'd0;
      us_r    <= 16'd0;
      cm_r    <= '0;
      rem_r   <= 10'd0;
      prev_r  <= 1'b0;
    end else if (step) begin
      presc_r <= presc_nxt;
      us_r    <= us_nxt;
      cm_r    <= cm_nxt;
      rem_r   <= rem_nxt;
      prev_r  <= echo_level;
    end
  end

endmodule
`default_nettype wire

// File: rtl/uer_ring.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uer_ring: distance ring buffer
// Holds measured distances; a push into a full ring overwrites the oldest
// entry. The entries at the read pointer and the one after it are read ahead
// into registers, so a pop in the same tick as a push needs no async read.
// ----------------------------------------------------------------------------
module uer_ring #(
  parameter int RING_DEPTH = uer_pkg::RING_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         step,
  input  wire logic                         push,
  input  wire logic [uer_pkg::DIST_W-1:0]   push_data,
  input  wire logic                         pop_req,
  input  wire logic                         clear,
  output uer_pkg::uer_ring_stat_t           stat
);
  import uer_pkg::*;

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);

  logic [DIST_W-1:0] mem [RING_DEPTH];
  logic [DIST_W-1:0] head0_r, head1_r;

  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;

  logic             full;
  logic [PTR_W-1:0] rp_a;
  logic [CNT_W-1:0] fill_a;
  logic             pop;
  logic [PTR_W-1:0] rp_nxt_p1;

  function automatic logic [PTR_W-1:0] nxt_idx(input logic [PTR_W-1:0] i);
    return (i == PTR_W'(RING_DEPTH - 1)) ? '0 : i + PTR_W'(1);
  endfunction

  always_comb begin
    full   = (fill_r == CNT_W'(RING_DEPTH));
    wp_nxt = wp_r;
    rp_a   = rp_r;
    fill_a = fill_r;
    if (push) begin
      wp_nxt = nxt_idx(wp_r);
      if (full) begin
        rp_a = nxt_idx(rp_r);
      end else begin
        fill_a = fill_r + CNT_W'(1);
      end
    end

    pop = pop_req && (fill_a != '0);
    // An entry pushed in this tick into an empty ring is read straight back.
    if (push && (rp_a == wp_r)) begin
      stat.pop_data = push_data;
    end else if (push && full) begin
      stat.pop_data = head1_r;
    end else begin
      stat.pop_data = head0_r;
    end

    rp_nxt   = rp_a;
    fill_nxt = fill_a;
    if (pop) begin
      rp_nxt   = nxt_idx(rp_a);
      fill_nxt = fill_a - CNT_W'(1);
    end
    if (clear) begin
      wp_nxt   = '0;
      rp_nxt   = '0;
      fill_nxt = '0;
    end
    rp_nxt_p1 = nxt_idx(rp_nxt);

    stat.popped = pop;
    stat.empty  = (fill_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (push) begin
        mem[wp_r] <= push_data;
      end
      head0_r <= (push && (wp_r == rp_nxt)) ? push_data : mem[rp_nxt];
      head1_r <= (push && (wp_r == rp_nxt_p1)) ? push_data : mem[rp_nxt_p1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      fill_r <= '0;
    end else if (step) begin
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      fill_r <= fill_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(RING_DEPTH))
    else $error("ring fill count exceeds depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == '0) |-> (rp_r == wp_r))
    else $error("empty ring with unequal pointers");
`endif

endmodule
`default_nettype wire

// File: rtl/uer_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uer_ctrl: trigger, periodic timer and request decoding
// Times the trigger pulse, runs the millisecond period of periodic sampling
// and acts on read and write requests.
// ----------------------------------------------------------------------------
module uer_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   step,
  input  wire logic [1:0]             opcode,
  input  wire logic                   write_value,
  input  wire logic                   mode,
  input  wire logic [9:0]             period_ms,
  input  wire uer_pkg::uer_echo_evt_t evt,
  input  wire logic                   popped,
  output uer_pkg::uer_ctrl_t          ctrl
);
  import uer_pkg::*;

  logic       sampling_r, sampling_nxt;
  logic       periodic_r, periodic_nxt;
  logic [3:0] trig_r, trig_nxt;
  logic [9:0] us_in_ms_r, us_in_ms_nxt;
  logic [9:0] ms_left_r, ms_left_nxt;

  logic [9:0]  period_eff;
  logic [10:0] us_sum;

  always_comb begin
    period_eff   = (period_ms == 10'd0) ? 10'd1 : period_ms;
    sampling_nxt = sampling_r;
    periodic_nxt = periodic_r;
    trig_nxt     = trig_r;
    us_in_ms_nxt = us_in_ms_r;
    ms_left_nxt  = ms_left_r;
    us_sum       = {1'b0, us_in_ms_r} + 11'd1;

    // A falling echo edge ends the measurement.
    if (evt.push) begin
      sampling_nxt = 1'b0;
    end
    if (evt.us_tick && (trig_r != 4'd0)) begin
      trig_nxt = trig_r - 4'd1;
    end

    if (periodic_r && evt.us_tick) begin
      if (us_sum >= US_PER_MS) begin
        us_in_ms_nxt = 10'd0;
        if (ms_left_r > 10'd1) begin
          ms_left_nxt = ms_left_r - 10'd1;
        end else begin
          ms_left_nxt  = period_eff;
          trig_nxt     = TRIG_US;
          sampling_nxt = 1'b1;
        end
      end else begin
        us_in_ms_nxt = us_sum[9:0];
      end
    end

    unique case (opcode)
      OP_READ: begin
        // Read on an empty ring starts a measurement unless one is running.
        if (!popped && !sampling_nxt) begin
          trig_nxt     = TRIG_US;
          sampling_nxt = 1'b1;
        end
      end
      OP_WRITE: begin
        if (mode == MODE_ONESHOT) begin
          if (!sampling_nxt) begin
            trig_nxt     = TRIG_US;
            sampling_nxt = 1'b1;
          end
        end else if (write_value) begin
          if (!periodic_r) begin
            periodic_nxt = 1'b1;
            us_in_ms_nxt = 10'd0;
            ms_left_nxt  = period_eff;
            trig_nxt     = TRIG_US;
            sampling_nxt = 1'b1;
          end
        end else begin
          periodic_nxt = 1'b0;
          sampling_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase

    ctrl.trigger    = (trig_nxt != 4'd0);
    ctrl.sampling   = sampling_nxt;
    ctrl.ring_clear = (opcode == OP_WRITE) && (mode == MODE_ONESHOT) && write_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sampling_r <= 1'b0;
      periodic_r <= 1'b0;
      trig_r     <= 4'd0;
      us_in_ms_r <= 10'd0;
      ms_left_r  <= 10'd0;
    end else if (step) begin
      sampling_r <= sampling_nxt;
      periodic_r <= periodic_nxt;
      trig_r     <= trig_nxt;
      us_in_ms_r <= us_in_ms_nxt;
      ms_left_r  <= ms_left_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_trig_bound: assert property (@(posedge clk) disable iff (!rst_n)
    trig_r <= TRIG_US)
    else $error("trigger countdown above pulse length");

  a_ms_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, us_in_ms_r} < US_PER_MS)
    else $error("microsecond-in-millisecond counter out of range");
`endif

endmodule
`default_nettype wire

// File: rtl/ultrasonic_echo_ranger.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger: ultrasonic range-finder controller
// Each input request is one sampled clock tick of the echo line plus an
// optional read or write command; each produces one result with the trigger
// level, any popped distance and the ring and sampling status.
// ----------------------------------------------------------------------------
//  Channel   Handshake             Payload
//  in_       in_valid / in_stall   uer_in_t  (opcode, echo_level, write_value)
//  out_      out_valid / out_stall uer_out_t (trigger, read, status)
//  APB       psel/penable/pready   mode, period_ms, ticks_per_us
//
//  One request per cycle sustained while out_stall is low; each request is held
//  in the input register and its result is registered in the output register.
//  All per-tick work is one combinational pass from the input register.
//  A stall on the output holds the result and backs up into in_stall.
//  Reset (rst_n low, synchronous) clears all control state; no clearing pass.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger #(
  parameter int RING_DEPTH = uer_pkg::RING_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,

  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire uer_pkg::uer_in_t             in_data,

  output logic                              out_valid,
  input  wire logic                         out_stall,
  output uer_pkg::uer_out_t                 out_data,

  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [uer_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [uer_pkg::DATA_W-1:0]   pwdata,
  output logic [uer_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);
  import uer_pkg::*;

  logic       mode_r;
  logic [9:0] period_r;
  logic [9:0] tpu_r;

  logic     in_valid_r;
  uer_in_t  in_item_r;
  logic     out_valid_r;
  uer_out_t out_data_r;
  logic     advance;

  uer_echo_evt_t  evt;
  uer_ring_stat_t rstat;
  uer_ctrl_t      ctrl;
  uer_out_t       result;

  // Configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_RST;
      period_r <= PERIOD_RST;
      tpu_r    <= TPU_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_MODE:   mode_r   <= pwdata[0];
        REG_PERIOD: period_r <= pwdata[9:0];
        REG_TPU:    tpu_r    <= pwdata[9:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MODE:   prdata = {{(DATA_W - 1){1'b0}}, mode_r};
      REG_PERIOD: prdata = {{(DATA_W - 10){1'b0}}, period_r};
      REG_TPU:    prdata = {{(DATA_W - 10){1'b0}}, tpu_r};
      default:    prdata = '0;
    endcase
  end

  // Request flow: input register, one processing pass, output register.
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_item_r <= in_data;
    end
    if (advance) begin
      out_data_r <= result;
    end
  end

  uer_echo_timer u_echo (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .echo_level   (in_item_r.echo_level),
    .ticks_per_us (tpu_r),
    .evt          (evt)
  );

  uer_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .push      (evt.push),
    .push_data (evt.push_cm),
    .pop_req   (in_item_r.opcode == OP_READ),
    .clear     (ctrl.ring_clear),
    .stat      (rstat)
  );

  uer_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .opcode      (in_item_r.opcode),
    .write_value (in_item_r.write_value),
    .mode        (mode_r),
    .period_ms   (period_r),
    .evt         (evt),
    .popped      (rstat.popped),
    .ctrl        (ctrl)
  );

  always_comb begin
    result.trigger_out   = ctrl.trigger;
    result.read_valid    = rstat.popped;
    result.read_distance = rstat.popped ? rstat.pop_data : '0;
    result.buffer_empty  = rstat.empty;
    result.sampling_busy = ctrl.sampling;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed request produced no result");

  a_no_dist_without_pop: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !rstat.popped |=> out_data_r.read_distance == '0)
    else $error("distance reported without a pop");
`endif

endmodule
`default_nettype wire
